// ===== hdl/laser_point_blanking_sequencer_defines.svh =====
// assertion macros for the laser point blanking sequencer checker
// no dependencies; taken in by the checker file

`ifndef LASER_POINT_BLANKING_SEQUENCER_DEFINES_SVH
`define LASER_POINT_BLANKING_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LPBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LPBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lpbs_pkg.sv =====
// shared types, constants and register codes of the blanking sequencer
// no dependencies

package lpbs_pkg;

  // default widths of the datapath
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int COLOR_BITS_DEF      = 8;

  // fixed register widths
  localparam int MODE_W     = 4;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam int OFFSET_W   = 18;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // mode bit positions
  localparam int MODE_FLIP_X = 0;
  localparam int MODE_FLIP_Y = 1;
  localparam int MODE_CAP_X  = 2;
  localparam int MODE_CAP_Y  = 3;

  // register reset values
  localparam logic [MODE_W-1:0]          MODE_RST   = '0;
  localparam logic signed [SCALE_W-1:0]  SCALE_RST  = 16'sd4096;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = '0;
  localparam logic [COUNT_W-1:0]         BLANK_RST  = 4'd15;
  localparam logic [COUNT_W-1:0]         END_RST    = 4'd15;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_SCALE_X  = 3'd1,
    REG_SCALE_Y  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_BLANK    = 3'd5,
    REG_END      = 3'd6
  } lpbs_reg_e;

  // configuration as seen by front and back
  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [SCALE_W-1:0]  scale_x;
    logic signed [SCALE_W-1:0]  scale_y;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
    logic [COUNT_W-1:0]         blank_count;
    logic [COUNT_W-1:0]         end_count;
  } lpbs_cfg_t;

  // phases of the output sequencer
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BLANK_PRE,
    PH_DWELL_PRE,
    PH_VERTEX,
    PH_DWELL_POST,
    PH_BLANK_POST
  } lpbs_phase_e;

endpackage

// ===== hdl/lpbs_fifo.sv =====
// short register queue between the transform front and the sequencer back
// depends on lpbs_pkg for the default depth

module lpbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lpbs_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNTW'(do_push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/lpbs_front.sv =====
// vertex transform front: flip, scale about centre, offset, cap or wrap
// depends on lpbs_pkg; feeds lpbs_fifo

module lpbs_front #(
  parameter int COORD_FRAC_BITS = lpbs_pkg::COORD_FRAC_BITS_DEF,
  parameter int COLOR_BITS      = lpbs_pkg::COLOR_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lpbs_pkg::lpbs_cfg_t       cfg_i,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [COORD_FRAC_BITS:0]  pos_x_i,
  input  logic [COORD_FRAC_BITS:0]  pos_y_i,
  input  logic [COLOR_BITS-1:0]     red_i,
  input  logic [COLOR_BITS-1:0]     green_i,
  input  logic [COLOR_BITS-1:0]     blue_i,
  input  logic [COLOR_BITS-1:0]     alpha_i,
  input  logic                      first_vertex_i,
  input  logic                      last_vertex_i,
  output logic                      q_push_o,
  output logic [2*(COORD_FRAC_BITS+1)+4*COLOR_BITS+1:0] q_data_o,
  input  logic                      q_full_i
);

  import lpbs_pkg::*;

  localparam int CW = COORD_FRAC_BITS + 1;
  localparam int FW = COORD_FRAC_BITS + 2;
  localparam int DW = COORD_FRAC_BITS + 3;
  localparam int PW = DW + SCALE_W;
  localparam int SW = PW - SCALE_FRAC;
  localparam int VW = (COORD_FRAC_BITS + 9 > OFFSET_W + 1) ? COORD_FRAC_BITS + 9
                                                            : OFFSET_W + 1;
  localparam int KW = 4 * COLOR_BITS;

  localparam logic signed [FW-1:0] OneF  = {2'b01, {COORD_FRAC_BITS{1'b0}}};
  localparam logic signed [DW-1:0] HalfD = {4'b0001, {(COORD_FRAC_BITS-1){1'b0}}};
  localparam logic signed [VW-1:0] HalfV =
    {{(VW-COORD_FRAC_BITS){1'b0}}, 1'b1, {(COORD_FRAC_BITS-1){1'b0}}};
  localparam logic signed [VW-1:0] OneV =
    {{(VW-COORD_FRAC_BITS-1){1'b0}}, 1'b1, {COORD_FRAC_BITS{1'b0}}};
  localparam logic [CW-1:0] OneC = {1'b1, {COORD_FRAC_BITS{1'b0}}};

  // optional flip v -> 1 - v
  function automatic logic signed [FW-1:0] flip_axis(input logic [CW-1:0] raw,
                                                     input logic flip);
    logic signed [FW-1:0] v;
    v = $signed(FW'(raw));
    if (flip) begin
      v = OneF - v;
    end
    return v;
  endfunction

  // floor-shift the product or take the unscaled value, offset, cap or wrap
  function automatic logic [CW-1:0] finish_axis(input logic signed [PW-1:0] prod,
                                                input logic signed [FW-1:0] vf,
                                                input logic scaling,
                                                input logic signed [OFFSET_W-1:0] off,
                                                input logic cap);
    logic signed [SW-1:0] sh;
    logic signed [VW-1:0] base;
    logic signed [VW-1:0] sum;
    logic [CW-1:0]        res;
    sh = prod[PW-1:SCALE_FRAC];
    if (scaling) begin
      base = $signed({{(VW-SW){sh[SW-1]}}, sh}) + HalfV;
    end else begin
      base = $signed({{(VW-FW){vf[FW-1]}}, vf});
    end
    sum = base + $signed({{(VW-OFFSET_W){off[OFFSET_W-1]}}, off});
    if (sum[VW-1]) begin
      // below zero: clamp, or fractional part with whole values going to one
      if (cap) begin
        res = '0;
      end else if (sum[COORD_FRAC_BITS-1:0] == '0) begin
        res = OneC;
      end else begin
        res = {1'b0, sum[COORD_FRAC_BITS-1:0]};
      end
    end else if (sum > OneV) begin
      res = cap ? OneC : {1'b0, sum[COORD_FRAC_BITS-1:0]};
    end else begin
      res = sum[CW-1:0];
    end
    return res;
  endfunction

  logic                 valid_a_q, valid_a_d;
  logic                 accept;
  logic signed [FW-1:0] vf_x, vf_y;
  logic signed [DW-1:0] d_x, d_y;
  logic signed [PW-1:0] prod_x_d, prod_y_d;
  logic signed [PW-1:0] prod_x_q, prod_y_q;
  logic signed [FW-1:0] vf_x_q, vf_y_q;
  logic [KW-1:0]        col_q;
  logic                 first_q, last_q;
  logic                 scaling;
  logic [CW-1:0]        res_x, res_y;

  // input side: flip, centre and multiply by the scale
  assign vf_x     = flip_axis(pos_x_i, cfg_i.mode[MODE_FLIP_X]);
  assign vf_y     = flip_axis(pos_y_i, cfg_i.mode[MODE_FLIP_Y]);
  assign d_x      = $signed({{(DW-FW){vf_x[FW-1]}}, vf_x}) - HalfD;
  assign d_y      = $signed({{(DW-FW){vf_y[FW-1]}}, vf_y}) - HalfD;
  assign prod_x_d = d_x * $signed(cfg_i.scale_x);
  assign prod_y_d = d_y * $signed(cfg_i.scale_y);

  // stage handshake towards the queue
  assign full_o   = valid_a_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_a_q && !q_full_i;

  always_comb begin
    valid_a_d = valid_a_q;
    if (accept) begin
      valid_a_d = 1'b1;
    end else if (q_push_o) begin
      valid_a_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= valid_a_d;
    end
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      vf_x_q   <= vf_x;
      vf_y_q   <= vf_y;
      col_q    <= {red_i, green_i, blue_i, alpha_i};
      first_q  <= first_vertex_i;
      last_q   <= last_vertex_i;
    end
  end

  // output side: finish both axes and pack the queue entry
  assign scaling = (cfg_i.scale_x != '0) || (cfg_i.scale_y != '0);
  assign res_x   = finish_axis(prod_x_q, vf_x_q, scaling, cfg_i.offset_x,
                               cfg_i.mode[MODE_CAP_X]);
  assign res_y   = finish_axis(prod_y_q, vf_y_q, scaling, cfg_i.offset_y,
                               cfg_i.mode[MODE_CAP_Y]);
  assign q_data_o = {res_x, res_y, col_q, first_q, last_q};

endmodule

// ===== hdl/lpbs_back.sv =====
// output sequencer: blanking, dwell and vertex beats per queued vertex
// depends on lpbs_pkg; reads from lpbs_fifo

module lpbs_back #(
  parameter int COORD_FRAC_BITS = lpbs_pkg::COORD_FRAC_BITS_DEF,
  parameter int COLOR_BITS      = lpbs_pkg::COLOR_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lpbs_pkg::lpbs_cfg_t       cfg_i,
  input  logic                      q_empty_i,
  input  logic [2*(COORD_FRAC_BITS+1)+4*COLOR_BITS+1:0] q_data_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [COORD_FRAC_BITS:0]  out_x_o,
  output logic [COORD_FRAC_BITS:0]  out_y_o,
  output logic [COLOR_BITS-1:0]     out_red_o,
  output logic [COLOR_BITS-1:0]     out_green_o,
  output logic [COLOR_BITS-1:0]     out_blue_o,
  output logic [COLOR_BITS-1:0]     out_alpha_o,
  output logic                      last_of_run_o
);

  import lpbs_pkg::*;

  localparam int CW = COORD_FRAC_BITS + 1;
  localparam int KW = 4 * COLOR_BITS;
  localparam int COL_LO = 2;
  localparam int Y_LO   = COL_LO + KW;
  localparam int X_LO   = Y_LO + CW;

  // next phase with a non-empty run
  function automatic lpbs_phase_e next_phase(input lpbs_phase_e ph,
                                             input logic first,
                                             input logic last,
                                             input logic [COUNT_W-1:0] bc,
                                             input logic [COUNT_W-1:0] ec);
    lpbs_phase_e nxt;
    nxt = PH_IDLE;
    case (ph)
      PH_IDLE: begin
        if (first && bc != '0)      nxt = PH_BLANK_PRE;
        else if (first && ec != '0) nxt = PH_DWELL_PRE;
        else                        nxt = PH_VERTEX;
      end
      PH_BLANK_PRE: begin
        nxt = (ec != '0) ? PH_DWELL_PRE : PH_VERTEX;
      end
      PH_DWELL_PRE: begin
        nxt = PH_VERTEX;
      end
      PH_VERTEX: begin
        if (last && ec != '0)      nxt = PH_DWELL_POST;
        else if (last && bc != '0) nxt = PH_BLANK_POST;
        else                       nxt = PH_IDLE;
      end
      PH_DWELL_POST: begin
        nxt = (bc != '0) ? PH_BLANK_POST : PH_IDLE;
      end
      default: begin
        nxt = PH_IDLE;
      end
    endcase
    return nxt;
  endfunction

  // run length loaded on entering a phase
  function automatic logic [COUNT_W-1:0] run_length(input lpbs_phase_e ph,
                                                    input logic [COUNT_W-1:0] bc,
                                                    input logic [COUNT_W-1:0] ec);
    logic [COUNT_W-1:0] n;
    case (ph)
      PH_BLANK_PRE, PH_BLANK_POST: n = bc;
      PH_DWELL_PRE, PH_DWELL_POST: n = ec;
      default:                     n = '0;
    endcase
    return n;
  endfunction

  lpbs_phase_e        state_q, state_d, nxt;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]      ent_x_q, ent_y_q;
  logic [KW-1:0]      ent_col_q;
  logic               ent_first_q, ent_last_q;
  logic               load, emit, blank, run_end, can_emit;
  logic               out_valid_q, out_valid_d;
  logic [CW-1:0]      out_x_q, out_y_q;
  logic [KW-1:0]      out_col_q;
  logic               out_last_q;

  assign can_emit = !out_valid_q || pop_i;

  // sequencer next state and beat generation
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    emit    = 1'b0;
    blank   = 1'b0;
    run_end = 1'b0;
    nxt     = PH_IDLE;
    case (state_q)
      PH_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          nxt     = next_phase(PH_IDLE, q_data_i[1], q_data_i[0],
                               cfg_i.blank_count, cfg_i.end_count);
          state_d = nxt;
          cnt_d   = run_length(nxt, cfg_i.blank_count, cfg_i.end_count);
        end
      end
      PH_BLANK_PRE, PH_DWELL_PRE, PH_VERTEX, PH_DWELL_POST, PH_BLANK_POST: begin
        if (can_emit) begin
          emit  = 1'b1;
          blank = (state_q == PH_BLANK_PRE) || (state_q == PH_BLANK_POST);
          if (state_q != PH_VERTEX && cnt_q > 4'd1) begin
            cnt_d = cnt_q - 1'b1;
          end else begin
            nxt     = next_phase(state_q, ent_first_q, ent_last_q,
                                 cfg_i.blank_count, cfg_i.end_count);
            state_d = nxt;
            cnt_d   = run_length(nxt, cfg_i.blank_count, cfg_i.end_count);
            run_end = (nxt == PH_IDLE);
          end
        end
      end
      default: begin
        state_d = PH_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PH_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // current vertex held for the whole run
  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_x_q     <= q_data_i[X_LO +: CW];
      ent_y_q     <= q_data_i[Y_LO +: CW];
      ent_col_q   <= q_data_i[COL_LO +: KW];
      ent_first_q <= q_data_i[1];
      ent_last_q  <= q_data_i[0];
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q    <= ent_x_q;
      out_y_q    <= ent_y_q;
      out_col_q  <= blank ? '0 : ent_col_q;
      out_last_q <= run_end;
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_red_o     = out_col_q[3*COLOR_BITS +: COLOR_BITS];
  assign out_green_o   = out_col_q[2*COLOR_BITS +: COLOR_BITS];
  assign out_blue_o    = out_col_q[COLOR_BITS +: COLOR_BITS];
  assign out_alpha_o   = out_col_q[0 +: COLOR_BITS];
  assign last_of_run_o = out_last_q;

endmodule

// ===== hdl/laser_point_blanking_sequencer.sv =====
// top level of the laser point blanking sequencer: registers, front, queue, back
// depends on lpbs_pkg, lpbs_front, lpbs_fifo and lpbs_back
//
//   channel   handshake          payload
//   vertex    push / full        pos_x_i pos_y_i red_i green_i blue_i alpha_i
//                                first_vertex_i last_vertex_i
//   result    empty / pop        out_x_o out_y_o out_red_o out_green_o
//                                out_blue_o out_alpha_o last_of_run_o
//   config    cfg_we_i           cfg_idx_i cfg_data_i
//
// the front takes one vertex a cycle unless the queue is full, into a 4-entry
// queue after one product stage; the back sequencer loads a vertex when idle,
// then emits its blank, dwell and vertex results as the result register frees;
// a plain vertex gives only the vertex result, first and last ones the runs too
// reset is asynchronous and active low; no clearing pass after it
// a low pop stalls the back only; the front keeps filling until the queue is full

module laser_point_blanking_sequencer #(
  parameter int COORD_FRAC_BITS = lpbs_pkg::COORD_FRAC_BITS_DEF,
  parameter int COLOR_BITS      = lpbs_pkg::COLOR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lpbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [COORD_FRAC_BITS:0]         pos_x_i,
  input  logic [COORD_FRAC_BITS:0]         pos_y_i,
  input  logic [COLOR_BITS-1:0]            red_i,
  input  logic [COLOR_BITS-1:0]            green_i,
  input  logic [COLOR_BITS-1:0]            blue_i,
  input  logic [COLOR_BITS-1:0]            alpha_i,
  input  logic                             first_vertex_i,
  input  logic                             last_vertex_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [COORD_FRAC_BITS:0]         out_x_o,
  output logic [COORD_FRAC_BITS:0]         out_y_o,
  output logic [COLOR_BITS-1:0]            out_red_o,
  output logic [COLOR_BITS-1:0]            out_green_o,
  output logic [COLOR_BITS-1:0]            out_blue_o,
  output logic [COLOR_BITS-1:0]            out_alpha_o,
  output logic                             last_of_run_o
);

  import lpbs_pkg::*;

  localparam int EW = 2 * (COORD_FRAC_BITS + 1) + 4 * COLOR_BITS + 2;

  lpbs_cfg_t     cfg_q, cfg_d;
  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:     cfg_d.mode        = cfg_data_i[MODE_W-1:0];
        REG_SCALE_X:  cfg_d.scale_x     = cfg_data_i[SCALE_W-1:0];
        REG_SCALE_Y:  cfg_d.scale_y     = cfg_data_i[SCALE_W-1:0];
        REG_OFFSET_X: cfg_d.offset_x    = cfg_data_i[OFFSET_W-1:0];
        REG_OFFSET_Y: cfg_d.offset_y    = cfg_data_i[OFFSET_W-1:0];
        REG_BLANK:    cfg_d.blank_count = cfg_data_i[COUNT_W-1:0];
        REG_END:      cfg_d.end_count   = cfg_data_i[COUNT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= MODE_RST;
      cfg_q.scale_x     <= SCALE_RST;
      cfg_q.scale_y     <= SCALE_RST;
      cfg_q.offset_x    <= OFFSET_RST;
      cfg_q.offset_y    <= OFFSET_RST;
      cfg_q.blank_count <= BLANK_RST;
      cfg_q.end_count   <= END_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // transform front
  lpbs_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .COLOR_BITS     (COLOR_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .alpha_i       (alpha_i),
    .first_vertex_i(first_vertex_i),
    .last_vertex_i (last_vertex_i),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata),
    .q_full_i      (q_full)
  );

  // decoupling queue
  lpbs_fifo #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  // output sequencer
  lpbs_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .COLOR_BITS     (COLOR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// ===== hdl/lpbs_checker.sv =====
// port-level checks of the blanking sequencer, bound to the top level
// depends on lpbs_pkg and laser_point_blanking_sequencer_defines.svh

`include "laser_point_blanking_sequencer_defines.svh"

module lpbs_checker #(
  parameter int COORD_FRAC_BITS = lpbs_pkg::COORD_FRAC_BITS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     empty,
  input logic                     pop,
  input logic [COORD_FRAC_BITS:0] out_x_o,
  input logic [COORD_FRAC_BITS:0] out_y_o,
  input logic                     last_of_run_o
);

  localparam logic [COORD_FRAC_BITS:0] OneC = {1'b1, {COORD_FRAC_BITS{1'b0}}};

  // positions never leave the unit range
  `LPBS_ASSERT_SAME(a_x_range, clk_i, rst_ni, !empty, out_x_o <= OneC, "out_x above one")
  `LPBS_ASSERT_SAME(a_y_range, clk_i, rst_ni, !empty, out_y_o <= OneC, "out_y above one")

  // a run goes on without a gap and at the same position
  `LPBS_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, !empty && pop && !last_of_run_o, !empty && $stable(out_x_o) && $stable(out_y_o), "run broken or moved")

  // a stalled beat stays put
  `LPBS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_x_o) && $stable(out_y_o) && $stable(last_of_run_o), "stalled beat changed")

endmodule

bind laser_point_blanking_sequencer lpbs_checker #(
  .COORD_FRAC_BITS(COORD_FRAC_BITS)
) u_lpbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .out_x_o      (out_x_o),
  .out_y_o      (out_y_o),
  .last_of_run_o(last_of_run_o)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for laser_point_blanking_sequencer: scoreboard class and drive tasks
// depends on lpbs_pkg and the sequencer rtl

module testbench;
  import lpbs_pkg::*;

  localparam int  CF         = COORD_FRAC_BITS_DEF;
  localparam int  CB         = COLOR_BITS_DEF;
  localparam longint COORD_ONE  = longint'(1) << CF;
  localparam longint COORD_HALF = longint'(1) << (CF - 1);
  localparam int  STALL_LIMIT = 1000;
  localparam int  DRAIN_WAIT  = 4;
  localparam int  TAIL_WAIT   = 40;
  localparam int  SHOWN_MAX   = 30;
  localparam int  RAND_PHASES = 12;
  localparam int  PHASE_ITEMS = 36;

  typedef struct packed {
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
    logic [CB-1:0] a;
  } rgba_t;

  typedef struct {
    logic [CF:0] x;
    logic [CF:0] y;
    rgba_t       col;
    bit          first;
    bit          last;
  } vertex_t;

  typedef struct {
    logic [CF:0] x;
    logic [CF:0] y;
    rgba_t       col;
    logic        last_of_run;
  } point_t;

  // expected laser points and the register copy they are worked out with
  class dwell_scoreboard;
    logic [MODE_W-1:0]          mode;
    logic signed [SCALE_W-1:0]  scale_x;
    logic signed [SCALE_W-1:0]  scale_y;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
    logic [COUNT_W-1:0]         blank_n;
    logic [COUNT_W-1:0]         dwell_n;
    point_t                     points_due[$];
    int                         errors;
    int                         checked;
    int                         vertices;

    function void load_reset();
      mode     = MODE_RST;
      scale_x  = SCALE_RST;
      scale_y  = SCALE_RST;
      offset_x = OFFSET_RST;
      offset_y = OFFSET_RST;
      blank_n  = BLANK_RST;
      dwell_n  = END_RST;
    endfunction

    function void set_reg(lpbs_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:     mode     = data[MODE_W-1:0];
        REG_SCALE_X:  scale_x  = data[SCALE_W-1:0];
        REG_SCALE_Y:  scale_y  = data[SCALE_W-1:0];
        REG_OFFSET_X: offset_x = data[OFFSET_W-1:0];
        REG_OFFSET_Y: offset_y = data[OFFSET_W-1:0];
        REG_BLANK:    blank_n  = data[COUNT_W-1:0];
        REG_END:      dwell_n  = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // flip, scale about the centre, offset, then cap or wrap
    function logic [CF:0] map_axis(logic [CF:0] raw, bit flip, bit scaling,
                                   longint scale, longint offset, bit cap);
      longint v;
      longint r;
      v = raw;
      if (flip) v = COORD_ONE - v;
      // arithmetic shift of a signed product rounds toward minus infinity
      if (scaling) v = (((v - COORD_HALF) * scale) >>> SCALE_FRAC) + COORD_HALF;
      v = v + offset;
      if (v < 0) begin
        if (cap) return '0;
        r = v % COORD_ONE;
        if (r < 0) r = r + COORD_ONE;
        // whole negative values land on one, not zero
        return (r == 0) ? (CF+1)'(COORD_ONE) : (CF+1)'(r);
      end
      if (v > COORD_ONE) begin
        if (cap) return (CF+1)'(COORD_ONE);
        return (CF+1)'(v % COORD_ONE);
      end
      return (CF+1)'(v);
    endfunction

    // expand one accepted vertex into its blank, dwell and vertex points
    function void note_vertex(vertex_t v);
      point_t run[$];
      point_t p;
      bit     scaling;
      scaling = (scale_x != 0) || (scale_y != 0);
      p.x = map_axis(v.x, mode[MODE_FLIP_X], scaling, scale_x, offset_x, mode[MODE_CAP_X]);
      p.y = map_axis(v.y, mode[MODE_FLIP_Y], scaling, scale_y, offset_y, mode[MODE_CAP_Y]);
      p.last_of_run = 1'b0;
      if (v.first) begin
        p.col = '0;
        repeat (blank_n) run = {run, p};
        p.col = v.col;
        repeat (dwell_n) run = {run, p};
      end
      p.col = v.col;
      run = {run, p};
      if (v.last) begin
        repeat (dwell_n) run = {run, p};
        p.col = '0;
        repeat (blank_n) run = {run, p};
      end
      run[run.size()-1].last_of_run = 1'b1;
      points_due = {points_due, run};
      vertices++;
    endfunction

    task report(string msg);
      if (errors < SHOWN_MAX) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("point %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_point(point_t got);
      point_t want;
      if (points_due.size() == 0) begin
        report($sformatf("point with no vertex behind it x=%0h y=%0h", got.x, got.y));
        return;
      end
      want = points_due.pop_front();
      compare("x", got.x, want.x);
      compare("y", got.y, want.y);
      compare("red", got.col.r, want.col.r);
      compare("green", got.col.g, want.col.g);
      compare("blue", got.col.b, want.col.b);
      compare("alpha", got.col.a, want.col.a);
      compare("last_of_run", got.last_of_run, want.last_of_run);
      checked++;
    endtask
  endclass

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push     = 1'b0;
  logic                   full;
  logic [CF:0]            pos_x    = '0;
  logic [CF:0]            pos_y    = '0;
  logic [CB-1:0]          red      = '0;
  logic [CB-1:0]          green    = '0;
  logic [CB-1:0]          blue     = '0;
  logic [CB-1:0]          alpha    = '0;
  logic                   first_v  = 1'b0;
  logic                   last_v   = 1'b0;
  logic                   empty;
  logic                   pop      = 1'b0;
  logic [CF:0]            out_x;
  logic [CF:0]            out_y;
  logic [CB-1:0]          out_red;
  logic [CB-1:0]          out_green;
  logic [CB-1:0]          out_blue;
  logic [CB-1:0]          out_alpha;
  logic                   out_last;

  bit              steady = 1'b0;
  int              settings;
  int              polylines;
  int              broken_lines;
  int              quiet;
  point_t          result_beat;
  dwell_scoreboard sb = new;

  laser_point_blanking_sequencer u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .alpha_i        (alpha),
    .first_vertex_i (first_v),
    .last_vertex_i  (last_v),
    .empty          (empty),
    .pop            (pop),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_red_o      (out_red),
    .out_green_o    (out_green),
    .out_blue_o     (out_blue),
    .out_alpha_o    (out_alpha),
    .last_of_run_o  (out_last)
  );

  always #2 clk = ~clk;

  // result side: check each popped beat, then pick pop for the next cycle
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      result_beat.x           = out_x;
      result_beat.y           = out_y;
      result_beat.col         = {out_red, out_green, out_blue, out_alpha};
      result_beat.last_of_run = out_last;
      sb.check_point(result_beat);
    end
    pop <= steady || ($urandom_range(0, 99) >= 34);
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (push && !full) || (pop && !empty)) quiet = 0;
    else quiet = quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d points outstanding",
               STALL_LIMIT, sb.points_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic vertex_t vtx(int x, int y, logic [31:0] rgba, bit f, bit l);
    vertex_t v;
    v.x     = (CF+1)'(x);
    v.y     = (CF+1)'(y);
    v.col   = rgba;
    v.first = f;
    v.last  = l;
    return v;
  endfunction

  // offer one vertex, with random idle cycles ahead of it unless steady is set
  task automatic send_vertex(vertex_t v);
    while (!steady && $urandom_range(0, 99) < 34) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    pos_x   <= v.x;
    pos_y   <= v.y;
    red     <= v.col.r;
    green   <= v.col.g;
    blue    <= v.col.b;
    alpha   <= v.col.a;
    first_v <= v.first;
    last_v  <= v.last;
    do @(posedge clk); while (full);
    sb.note_vertex(v);
  endtask

  task automatic write_reg(lpbs_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // drain the block, then load a whole register set
  task automatic apply_setting(int mode, int sx, int sy, int ox, int oy, int bl, int dw);
    push <= 1'b0;
    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_SCALE_X, CFG_DATA_W'(sx));
    write_reg(REG_SCALE_Y, CFG_DATA_W'(sy));
    write_reg(REG_OFFSET_X, CFG_DATA_W'(ox));
    write_reg(REG_OFFSET_Y, CFG_DATA_W'(oy));
    write_reg(REG_BLANK, CFG_DATA_W'(bl));
    write_reg(REG_END, CFG_DATA_W'(dw));
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic int pick_scale();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 4096;
      2:       return -4096;
      3:       return 32767;
      4:       return -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 65536;
      2:       return -65536;
      default: return int'($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  initial begin
    int      ph;
    int      sent;
    int      len;
    bit      broken;
    rgba_t   hue;
    vertex_t v;

    sb.load_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: full blank and dwell runs, identity scale, wrap
    send_vertex(vtx(0, 65536, 32'hffffffff, 1, 1));
    send_vertex(vtx(131071, 131071, 32'h00000000, 0, 0));
    send_vertex(vtx(1, 65535, 32'h55aa55aa, 1, 0));
    send_vertex(vtx(32768, 100, 32'haa55aa55, 0, 1));

    // scaling off, whole offsets: whole negative, exact one, whole above one
    apply_setting(0, 0, 0, -65536, 65536, 0, 0);
    send_vertex(vtx(0, 0, 32'h01020304, 0, 0));
    send_vertex(vtx(1, 1, 32'h80402010, 0, 0));
    send_vertex(vtx(65536, 65536, 32'hfedcba98, 0, 0));
    send_vertex(vtx(131071, 65535, 32'h7f7f7f7f, 1, 1));

    // flip and cap on both axes, extreme scales and offsets
    apply_setting(15, -32768, 32767, 65536, -65536, 1, 0);
    send_vertex(vtx(0, 0, 32'hffffffff, 0, 0));
    send_vertex(vtx(65536, 65536, 32'h00ff00ff, 0, 0));
    send_vertex(vtx(131071, 0, 32'hff00ff00, 1, 0));
    send_vertex(vtx(40000, 20000, 32'h12345678, 0, 1));

    // flip with wrap, zero y scale collapses y to the centre
    apply_setting(3, 4096, 0, -100, 65536, 0, 15);
    send_vertex(vtx(0, 0, 32'h0f0f0f0f, 0, 0));
    send_vertex(vtx(65536, 131071, 32'hf0f0f0f0, 0, 0));
    send_vertex(vtx(131071, 32768, 32'h33333333, 1, 1));
    send_vertex(vtx(12345, 54321, 32'hcccccccc, 0, 0));

    // cap y only, mirrored x scale, half offsets
    apply_setting(8, -4096, 4096, -32768, 32768, 15, 15);
    send_vertex(vtx(0, 65536, 32'h11223344, 1, 0));
    send_vertex(vtx(65536, 0, 32'h55667788, 0, 0));
    send_vertex(vtx(32767, 32769, 32'h99aabbcc, 0, 0));
    send_vertex(vtx(131071, 131071, 32'hddeeff00, 0, 1));

    // random polylines over a series of register settings
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      steady = (ph == 4) || (ph == 9);
      if (ph == 0)
        apply_setting(15, 32767, 32767, 65536, 65536, 15, 15);
      else if (ph == 1)
        apply_setting(0, -32768, -32768, -65536, -65536, 0, 0);
      else if (ph == 6)
        apply_setting($urandom_range(0, 15), 0, 0, pick_offset(), pick_offset(),
                      $urandom_range(0, 15), $urandom_range(0, 15));
      else
        apply_setting($urandom_range(0, 15), pick_scale(), pick_scale(), pick_offset(),
                      pick_offset(), $urandom_range(0, 15), $urandom_range(0, 15));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len    = $urandom_range(1, 6);
        hue    = $urandom;
        broken = ($urandom_range(0, 9) < 2);
        polylines++;
        if (broken) broken_lines++;
        for (int i = 0; i < len; i++) begin
          v.x   = (CF+1)'(pick_coord());
          v.y   = (CF+1)'(pick_coord());
          v.col = broken ? rgba_t'($urandom) : hue;
          // broken lines carry random flags, well-formed ones mark their ends
          v.first = broken ? bit'($urandom_range(0, 1)) : (i == 0);
          v.last  = broken ? bit'($urandom_range(0, 1)) : (i == len - 1);
          send_vertex(v);
          sent++;
        end
      end
    end
    steady = 1'b0;
    push <= 1'b0;

    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d vertices over %0d register settings, %0d points checked",
             sb.vertices, settings + 1, sb.checked);
    $display("random part: %0d polylines, %0d with scrambled flags",
             polylines, broken_lines);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lpbs_pkg.sv
hdl/lpbs_fifo.sv
hdl/lpbs_front.sv
hdl/lpbs_back.sv
hdl/laser_point_blanking_sequencer.sv
hdl/lpbs_checker.sv
bench/testbench.sv
